FILE: hw/rtl/mld_pkg.sv
// Shared types, constants and helpers for the Maidenhead locator decoder.
package mld_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned NumChars = 8;
  localparam int unsigned LenW = 4;
  localparam int unsigned LatW = 21;
  localparam int unsigned LonW = 22;
  localparam int unsigned LonBW = 17;
  localparam int unsigned LatBW = 16;

  // Length codes.
  localparam logic [1:0] LEN_2 = 2'd0;
  localparam logic [1:0] LEN_4 = 2'd1;
  localparam logic [1:0] LEN_6 = 2'd2;
  localparam logic [1:0] LEN_8 = 2'd3;

  // Steps in half arcseconds.
  localparam logic [LonW-1:0] FIELD_LON_STEP = 22'd144000;
  localparam logic [LatW-1:0] FIELD_LAT_STEP = 21'd72000;
  localparam logic [LonW-1:0] SQ_LON_STEP = 22'd14400;
  localparam logic [LatW-1:0] SQ_LAT_STEP = 21'd7200;
  localparam logic [LonBW-1:0] SUB_LON_STEP = 17'd600;
  localparam logic [LatBW-1:0] SUB_LAT_STEP = 16'd300;
  localparam logic [LonBW-1:0] EXT_LON_STEP = 17'd60;
  localparam logic [LatBW-1:0] EXT_LAT_STEP = 16'd30;

  // Centre offsets.
  localparam logic [LonBW-1:0] CTR_LON_2 = 17'd72000;
  localparam logic [LatBW-1:0] CTR_LAT_2 = 16'd36000;
  localparam logic [LonBW-1:0] CTR_LON_4 = 17'd7200;
  localparam logic [LatBW-1:0] CTR_LAT_4 = 16'd3600;
  localparam logic [LonBW-1:0] CTR_LON_6 = 17'd300;
  localparam logic [LatBW-1:0] CTR_LAT_6 = 16'd150;
  localparam logic [LonBW-1:0] CTR_LON_8 = 17'd30;
  localparam logic [LatBW-1:0] CTR_LAT_8 = 16'd15;

  // Origin shifts (180 and 90 degrees).
  localparam logic [LonW:0] LON_ORIGIN = 23'd1296000;
  localparam logic [LatW:0] LAT_ORIGIN = 22'd648000;

  localparam logic [CharW-1:0] CH_A_LO = 8'h61;  // 'a'
  localparam logic [CharW-1:0] CH_Z_LO = 8'h7a;  // 'z'
  localparam logic [CharW-1:0] CH_A = 8'h41;     // 'A'
  localparam logic [CharW-1:0] CH_R = 8'h52;     // 'R'
  localparam logic [CharW-1:0] CH_X = 8'h58;     // 'X'
  localparam logic [CharW-1:0] CH_0 = 8'h30;     // '0'
  localparam logic [CharW-1:0] CH_9 = 8'h39;     // '9'
  localparam logic [CharW-1:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic       ok;
    logic [1:0] len_code;
    logic [4:0] f_lon;
    logic [4:0] f_lat;
    logic [3:0] sq_lon;
    logic [3:0] sq_lat;
    logic [4:0] ss_lon;
    logic [4:0] ss_lat;
    logic [3:0] ex_lon;
    logic [3:0] ex_lat;
  } mld_idx_t;

  function automatic logic [CharW-1:0] fold_upper(input logic [CharW-1:0] c);
    if (c >= CH_A_LO && c <= CH_Z_LO) begin
      return c - CASE_DELTA;
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/maidenhead_locator_decode_unit.sv
// Top level of the Maidenhead locator decoder: three-stage pipeline with stream ports.
// Decodes a 2, 4, 6 or 8 character locator (case-insensitive) into the centre latitude and
// longitude of the named square in signed half-arcsecond units. One transfer in and one out
// per cycle while m_tready is high; a locator passes the check/index stage, the constant-multiply
// stage and the final add into the output register. Each stage advances when the next one is
// empty or moving, so bubbles collapse and the block keeps accepting while a result waits,
// until the earlier stages fill. Invalid locators give m_tuser = 0 with both coordinates zero.
module maidenhead_locator_decode_unit
  import mld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // grid_char_0..grid_char_7 [63:0] (8 bits each), grid_length [67:64], zero pad [71:68]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // latitude_half_arcsec [20:0], longitude_half_arcsec [42:21], zero pad [47:43]
  output logic [47:0] m_tdata,
  // locator_valid [0]
  output logic        m_tuser
);

  mld_idx_t idx_in;

  logic v1, v2, v3;
  logic en1, en2, en3;

  mld_idx_t             p1;
  logic                 ok2;
  logic [LonW-1:0]      lon_a2;
  logic [LonBW-1:0]     lon_b2;
  logic [LatW-1:0]      lat_a2;
  logic [LatBW-1:0]     lat_b2;
  logic                 ok3;
  logic [LonW-1:0]      lon3;
  logic [LatW-1:0]      lat3;

  logic [LonW-1:0]      lon_a_next;
  logic [LonBW-1:0]     lon_b_next;
  logic [LatW-1:0]      lat_a_next;
  logic [LatBW-1:0]     lat_b_next;
  logic [LonBW-1:0]     ctr_lon;
  logic [LatBW-1:0]     ctr_lat;
  logic [LonW:0]        lon_sum;
  logic [LatW:0]        lat_sum;

  mld_parse u_parse (
    .grid_chars  (s_tdata[CharW*NumChars-1:0]),
    .grid_length (s_tdata[CharW*NumChars +: LenW]),
    .idx         (idx_in)
  );

  assign en3      = !v3 || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= s_tvalid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  // Stage 1: checked indices.
  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) begin
      p1 <= idx_in;
    end
  end

  // Stage 2: constant multiplies, partial sums.
  always_comb begin
    case (p1.len_code)
      LEN_2: begin
        ctr_lon = CTR_LON_2;
        ctr_lat = CTR_LAT_2;
      end
      LEN_4: begin
        ctr_lon = CTR_LON_4;
        ctr_lat = CTR_LAT_4;
      end
      LEN_6: begin
        ctr_lon = CTR_LON_6;
        ctr_lat = CTR_LAT_6;
      end
      default: begin
        ctr_lon = CTR_LON_8;
        ctr_lat = CTR_LAT_8;
      end
    endcase
    lon_a_next = LonW'(p1.f_lon) * FIELD_LON_STEP + LonW'(p1.sq_lon) * SQ_LON_STEP;
    lat_a_next = LatW'(p1.f_lat) * FIELD_LAT_STEP + LatW'(p1.sq_lat) * SQ_LAT_STEP;
    lon_b_next = LonBW'(p1.ss_lon) * SUB_LON_STEP + LonBW'(p1.ex_lon) * EXT_LON_STEP
                 + ctr_lon;
    lat_b_next = LatBW'(p1.ss_lat) * SUB_LAT_STEP + LatBW'(p1.ex_lat) * EXT_LAT_STEP
                 + ctr_lat;
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      ok2    <= p1.ok;
      lon_a2 <= lon_a_next;
      lon_b2 <= lon_b_next;
      lat_a2 <= lat_a_next;
      lat_b2 <= lat_b_next;
    end
  end

  // Stage 3: final sum and origin shift into the output register.
  assign lon_sum = {1'b0, lon_a2} + (LonW+1)'(lon_b2) - LON_ORIGIN;
  assign lat_sum = {1'b0, lat_a2} + (LatW+1)'(lat_b2) - LAT_ORIGIN;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      ok3  <= ok2;
      lon3 <= ok2 ? lon_sum[LonW-1:0] : '0;
      lat3 <= ok2 ? lat_sum[LatW-1:0] : '0;
    end
  end

  assign m_tvalid = v3;
  assign m_tuser  = ok3;
  assign m_tdata  = {5'd0, lon3, lat3};

endmodule

FILE: hw/rtl/mld_parse.sv
// Case folding, character range checks and index extraction.
module mld_parse
  import mld_pkg::*;
(
  input  logic [CharW*NumChars-1:0] grid_chars,
  input  logic [LenW-1:0]           grid_length,
  output mld_idx_t                  idx
);

  logic [CharW-1:0] ch [NumChars];
  logic             len_ok;
  logic             pair0_ok;
  logic             pair1_ok;
  logic             pair2_ok;
  logic             pair3_ok;
  logic             ok;
  logic             use_sq;
  logic             use_ss;
  logic             use_ex;
  logic [CharW-1:0] d [NumChars];

  always_comb begin
    for (int i = 0; i < NumChars; i++) begin
      ch[i] = fold_upper(grid_chars[i*CharW +: CharW]);
    end
  end

  always_comb begin
    for (int i = 0; i < NumChars; i++) begin
      if (i == 2 || i == 3 || i == 6 || i == 7) begin
        d[i] = ch[i] - CH_0;
      end else begin
        d[i] = ch[i] - CH_A;
      end
    end
  end

  assign len_ok = (grid_length == 4'd2) || (grid_length == 4'd4) ||
                  (grid_length == 4'd6) || (grid_length == 4'd8);
  assign use_sq = grid_length >= 4'd4;
  assign use_ss = grid_length >= 4'd6;
  assign use_ex = grid_length >= 4'd8;

  assign pair0_ok = ch[0] >= CH_A && ch[0] <= CH_R && ch[1] >= CH_A && ch[1] <= CH_R;
  assign pair1_ok = ch[2] >= CH_0 && ch[2] <= CH_9 && ch[3] >= CH_0 && ch[3] <= CH_9;
  assign pair2_ok = ch[4] >= CH_A && ch[4] <= CH_X && ch[5] >= CH_A && ch[5] <= CH_X;
  assign pair3_ok = ch[6] >= CH_0 && ch[6] <= CH_9 && ch[7] >= CH_0 && ch[7] <= CH_9;

  assign ok = len_ok && pair0_ok && (!use_sq || pair1_ok) && (!use_ss || pair2_ok) &&
              (!use_ex || pair3_ok);

  always_comb begin
    idx          = '0;
    idx.ok       = ok;
    idx.len_code = grid_length[2:1] - 2'd1;
    if (ok) begin
      idx.f_lon = d[0][4:0];
      idx.f_lat = d[1][4:0];
      if (use_sq) begin
        idx.sq_lon = d[2][3:0];
        idx.sq_lat = d[3][3:0];
      end
      if (use_ss) begin
        idx.ss_lon = d[4][4:0];
        idx.ss_lat = d[5][4:0];
      end
      if (use_ex) begin
        idx.ex_lon = d[6][3:0];
        idx.ex_lat = d[7][3:0];
      end
    end
  end

endmodule

FILE: verif/maidenhead_locator_decode_checker.sv
// Checker for the locator decoder: predicts each decoded coordinate pair and compares outputs.
module maidenhead_locator_decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tuser,
  output int          mismatch_cnt,
  output int          pending_cnt
);

  localparam int UP_A  = 65;
  localparam int UP_R  = 82;
  localparam int UP_X  = 88;
  localparam int DIG_0 = 48;
  localparam int DIG_9 = 57;
  localparam int LOW_A = 97;
  localparam int LOW_Z = 122;

  typedef struct packed {
    logic        valid;
    logic [20:0] lat;
    logic [21:0] lon;
  } grid_center_t;

  grid_center_t center_q[$];
  int           errs = 0;

  function automatic bit in_span(input int c, input int lo, input int hi);
    return c >= lo && c <= hi;
  endfunction

  function automatic grid_center_t locate_center(input logic [71:0] word);
    int           c[8];
    int           n;
    int           lat;
    int           lon;
    bit           ok;
    grid_center_t res;
    for (int i = 0; i < 8; i++) begin
      c[i] = int'(word[8*i +: 8]);
      if (c[i] >= LOW_A && c[i] <= LOW_Z) c[i] = c[i] - 32;
    end
    n = int'(word[67:64]);
    lat = 0;
    lon = 0;
    ok = (n == 2 || n == 4 || n == 6 || n == 8);
    if (ok) ok = in_span(c[0], UP_A, UP_R) && in_span(c[1], UP_A, UP_R);
    if (ok && n >= 4) ok = in_span(c[2], DIG_0, DIG_9) && in_span(c[3], DIG_0, DIG_9);
    if (ok && n >= 6) ok = in_span(c[4], UP_A, UP_X) && in_span(c[5], UP_A, UP_X);
    if (ok && n >= 8) ok = in_span(c[6], DIG_0, DIG_9) && in_span(c[7], DIG_0, DIG_9);
    if (ok) begin
      lon = (c[0] - UP_A) * 144000 - 1296000;
      lat = (c[1] - UP_A) * 72000 - 648000;
      if (n == 2) begin
        lon += 72000;
        lat += 36000;
      end else begin
        lon += (c[2] - DIG_0) * 14400;
        lat += (c[3] - DIG_0) * 7200;
        if (n == 4) begin
          lon += 7200;
          lat += 3600;
        end else begin
          lon += (c[4] - UP_A) * 600;
          lat += (c[5] - UP_A) * 300;
          if (n == 6) begin
            lon += 300;
            lat += 150;
          end else begin
            lon += (c[6] - DIG_0) * 60 + 30;
            lat += (c[7] - DIG_0) * 30 + 15;
          end
        end
      end
    end
    res.valid = ok;
    res.lat = lat[20:0];
    res.lon = lon[21:0];
    return res;
  endfunction

  always @(posedge clk) begin
    grid_center_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) center_q.push_back(locate_center(s_tdata));
      if (m_tvalid && m_tready) begin
        if (center_q.size() == 0) begin
          $error("unexpected output transfer: tuser %0b tdata %h", m_tuser, m_tdata);
          errs++;
        end else begin
          want = center_q.pop_front();
          if (m_tuser !== want.valid) begin
            $error("locator_valid: expected %0d, got %0d", want.valid, m_tuser);
            errs++;
          end
          if (m_tdata[20:0] !== want.lat) begin
            $error("latitude_half_arcsec: expected %0d, got %0d",
                   $signed(want.lat), $signed(m_tdata[20:0]));
            errs++;
          end
          if (m_tdata[42:21] !== want.lon) begin
            $error("longitude_half_arcsec: expected %0d, got %0d",
                   $signed(want.lon), $signed(m_tdata[42:21]));
            errs++;
          end
        end
      end
    end
    mismatch_cnt <= errs;
    pending_cnt <= center_q.size();
  end

endmodule

FILE: verif/testbench.sv
// Top of the locator decoder testbench: clock, reset, stimulus, backpressure and verdict.
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int UP_A  = 65;
  localparam int DIG_0 = 48;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;

  int  mismatch_cnt;
  int  pending_cnt;
  int  sent = 0;
  int  cycles = 0;
  wire calm = (sent >= 640) || (sent >= 300 && sent < 360);

  logic [7:0] near_miss[14] = '{8'h40, 8'h53, 8'h5b, 8'h60, 8'h73, 8'h7b, 8'h2f,
                                8'h3a, 8'h59, 8'h79, 8'h5a, 8'hc1, 8'h80, 8'hff};

  always #5 clk = ~clk;

  maidenhead_locator_decode_unit i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  maidenhead_locator_decode_checker i_checker (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .mismatch_cnt(mismatch_cnt),
    .pending_cnt(pending_cnt)
  );

  function automatic logic [71:0] grid_word(input string s, input int n, input logic [7:0] pad);
    logic [71:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = (i < s.len()) ? s[i] : pad;
    w[67:64] = n[3:0];
    return w;
  endfunction

  function automatic logic [7:0] pick_char(input int base, input int span, input bit mixed);
    int v;
    v = base + int'($urandom_range(0, span));
    if (mixed && $urandom_range(0, 1) == 1) v += 32;
    return v[7:0];
  endfunction

  function automatic logic [71:0] random_grid();
    logic [7:0]  c[8];
    logic [71:0] w;
    int          kind;
    int          n;
    int          pos;
    kind = $urandom_range(0, 99);
    n = 2 * $urandom_range(1, 4);
    c[0] = pick_char(UP_A, 17, 1'b1);
    c[1] = pick_char(UP_A, 17, 1'b1);
    c[2] = pick_char(DIG_0, 9, 1'b0);
    c[3] = pick_char(DIG_0, 9, 1'b0);
    c[4] = pick_char(UP_A, 23, 1'b1);
    c[5] = pick_char(UP_A, 23, 1'b1);
    c[6] = pick_char(DIG_0, 9, 1'b0);
    c[7] = pick_char(DIG_0, 9, 1'b0);
    for (int i = n; i < 8; i++) c[i] = 8'($urandom_range(0, 255));
    if (kind >= 75 && kind < 90) begin
      pos = $urandom_range(0, n - 1);
      if ($urandom_range(0, 1) == 1) c[pos] = 8'($urandom_range(0, 255));
      else c[pos] = near_miss[$urandom_range(0, 13)];
    end else if (kind >= 90) begin
      for (int i = 0; i < 8; i++) c[i] = 8'($urandom_range(0, 255));
      n = $urandom_range(0, 15);
    end
    w = '0;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = c[i];
    w[67:64] = n[3:0];
    return w;
  endfunction

  task automatic offer(input logic [71:0] w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tdata <= w;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : sink
    int  hold;
    bit  long_done;
    hold = 0;
    long_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else if (!long_done && sent >= 120) begin
        long_done = 1'b1;
        hold = 400;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : source
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all four lengths, both corners, lower case
    offer(grid_word("AA", 2, 8'h00));
    offer(grid_word("RR", 2, 8'hff));
    offer(grid_word("rr", 2, 8'h20));
    offer(grid_word("AA00", 4, 8'hff));
    offer(grid_word("RR99", 4, 8'h00));
    offer(grid_word("AA00AA", 6, 8'hff));
    offer(grid_word("RR99XX", 6, 8'h00));
    offer(grid_word("rr99xx", 6, 8'h7f));
    offer(grid_word("AA00AA00", 8, 8'h00));
    offer(grid_word("RR99XX99", 8, 8'h00));
    offer(grid_word("jN58Td25", 8, 8'h00));
    // bad lengths
    offer(grid_word("AA00AA00", 0, 8'h00));
    offer(grid_word("AA00AA00", 1, 8'h00));
    offer(grid_word("AA00AA00", 7, 8'h00));
    offer(grid_word("AA00AA00", 15, 8'h00));
    // out-of-range characters, edges of each span
    offer(grid_word("SA", 2, 8'h00));
    offer(grid_word("A@", 2, 8'h00));
    offer(grid_word("sa", 2, 8'h00));
    offer(grid_word("AA/0", 4, 8'h00));
    offer(grid_word("AA0:", 4, 8'h00));
    offer(grid_word("AA00YA", 6, 8'h00));
    offer(grid_word("AA00A{", 6, 8'h00));
    offer(grid_word("AA00AA0:", 8, 8'h00));
    // high bytes are never folded
    offer(grid_word(string'({8'hc1, 8'h41}), 2, 8'h00));
    offer(grid_word(string'({8'h41, 8'he1}), 2, 8'h00));

    repeat (700) offer(random_grid());

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: maidenhead_locator_decode_unit.f
hw/rtl/mld_pkg.sv
hw/rtl/mld_parse.sv
hw/rtl/maidenhead_locator_decode_unit.sv
verif/maidenhead_locator_decode_checker.sv
verif/testbench.sv
